### sv/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared constants and helpers for the SHA-1 message digest engine.
// ----------------------------------------------------------------------------
package sha1md_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned BufWords   = 16;
   localparam int unsigned Rounds     = 80;
   localparam int unsigned NumChain   = 5;

   typedef logic [WordWidth-1:0]        word_type;
   typedef logic [$clog2(BufWords)-1:0] widx_type;
   typedef logic [$clog2(Rounds)-1:0]   round_type;

   localparam word_type H0 = 32'h6745_2301;
   localparam word_type H1 = 32'hEFCD_AB89;
   localparam word_type H2 = 32'h98BA_DCFE;
   localparam word_type H3 = 32'h1032_5476;
   localparam word_type H4 = 32'hC3D2_E1F0;

   localparam word_type K0 = 32'h5A82_7999;
   localparam word_type K1 = 32'h6ED9_EBA1;
   localparam word_type K2 = 32'h8F1B_BCDC;
   localparam word_type K3 = 32'hCA62_C1D6;

   localparam logic [7:0] PadMark = 8'h80;

   localparam round_type LastRound  = round_type'(Rounds - 1);
   localparam round_type SchedStart = round_type'(BufWords);

   function automatic word_type rotl1(input word_type x);
      return {x[WordWidth-2:0], x[WordWidth-1]};
   endfunction

   function automatic word_type rotl5(input word_type x);
      return {x[WordWidth-6:0], x[WordWidth-1 -: 5]};
   endfunction

   function automatic word_type rotl30(input word_type x);
      return {x[1:0], x[WordWidth-1:2]};
   endfunction

endpackage

### sv/sha1_message_digest_top.sv
// ----------------------------------------------------------------------------
// sha1_message_digest_top
// SHA-1 digest engine, one message byte per transfer, digest as five words.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one item per transfer: a byte (used when req_byte_present
//  is high) and req_end_of_message marking the last item of a message. An end
//  item without a byte closes the message as is, so empty messages work.
//  rsp_* carries one digest per message, rsp_digest_word0 first in big-endian
//  byte order, after the transfer that ends the message.
//  Bytes are packed into words and written to a 16-word block buffer memory.
//  A full block is compressed at one round per cycle (load, the rounds, then
//  add); bytes are not taken meanwhile, so the round loop and the single
//  buffer read port limit the byte rate.
//  Closing a message pads and writes the length word by word (up to 18 writes)
//  then compresses one or two blocks before the digest is delivered.
//  req_stall is high while a block is padded or compressed and while a
//  finished digest waits for the output register.
//  A stalled digest waits in the output register; bytes of the next message
//  are still taken, and the next digest is held back until that one is gone.
//  Synchronous reset restores the initial chaining words and an empty message.
// ----------------------------------------------------------------------------
module sha1_message_digest_top
   import sha1md_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word0,
   output logic [31:0] rsp_digest_word1,
   output logic [31:0] rsp_digest_word2,
   output logic [31:0] rsp_digest_word3,
   output logic [31:0] rsp_digest_word4
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_ZERO, ST_LEN, ST_LOAD, ST_ROUND, ST_ADD, ST_DELIVER
   } state_type;

   typedef enum logic [1:0] {
      POST_IDLE, POST_PAD, POST_ZERO, POST_DELIVER
   } post_type;

   state_type   state_ff,  state_in;
   post_type    post_ff,   post_in;
   logic [5:0]  fill_ff,   fill_in;
   logic [63:0] bitlen_ff, bitlen_in;
   logic [23:0] wacc_ff,   wacc_in;
   widx_type    widx_ff,   widx_in;
   logic        two_ff,    two_in;
   round_type   round_ff,  round_in;
   word_type    h_ff [NumChain];
   word_type    h_in [NumChain];
   word_type    a_ff, b_ff, c_ff, d_ff, e_ff;
   word_type    a_in, b_in, c_in, d_in, e_in;
   word_type    sched_ff [BufWords];
   word_type    sched_in [BufWords];
   logic        rsp_valid_ff, rsp_valid_in;
   word_type    dig_ff [NumChain];
   word_type    dig_in [NumChain];

   word_type    buf_mem [BufWords];
   word_type    rd_q_ff;
   logic        mem_we;
   widx_type    mem_waddr;
   widx_type    mem_raddr;
   word_type    mem_wdata;

   logic        req_xfer;
   word_type    w_cur, f_cur, k_cur, t_cur, pad_word;
   widx_type    fw;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign fw        = fill_ff[5:2];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         buf_mem[mem_waddr] <= mem_wdata;
      end
      rd_q_ff <= buf_mem[mem_raddr];
   end

   always_comb begin
      w_cur = (round_ff < SchedStart) ? rd_q_ff :
              rotl1(sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0]);
      if (round_ff < round_type'(20)) begin
         f_cur = (b_ff & c_ff) | (~b_ff & d_ff);
         k_cur = K0;
      end else if (round_ff < round_type'(40)) begin
         f_cur = b_ff ^ c_ff ^ d_ff;
         k_cur = K1;
      end else if (round_ff < round_type'(60)) begin
         f_cur = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_cur = K2;
      end else begin
         f_cur = b_ff ^ c_ff ^ d_ff;
         k_cur = K3;
      end
      t_cur = rotl5(a_ff) + f_cur + e_ff + k_cur + w_cur;

      case (fill_ff[1:0])
         2'd0:    pad_word = {PadMark, 24'h0};
         2'd1:    pad_word = {wacc_ff[7:0], PadMark, 16'h0};
         2'd2:    pad_word = {wacc_ff[15:0], PadMark, 8'h0};
         2'd3:    pad_word = {wacc_ff[23:0], PadMark};
         default: pad_word = '0;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      post_in   = post_ff;
      fill_in   = fill_ff;
      bitlen_in = bitlen_ff;
      wacc_in   = wacc_ff;
      widx_in   = widx_ff;
      two_in    = two_ff;
      round_in  = round_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      e_in      = e_ff;
      h_in      = h_ff;
      sched_in  = sched_ff;
      dig_in    = dig_ff;
      mem_we    = 1'b0;
      mem_waddr = widx_ff;
      mem_wdata = '0;
      mem_raddr = '0;

      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_byte_present) begin
                  wacc_in   = {wacc_ff[15:0], req_msg_byte};
                  fill_in   = fill_ff + 6'd1;
                  bitlen_in = bitlen_ff + 64'd8;
                  if (fill_ff[1:0] == 2'd3) begin
                     mem_we    = 1'b1;
                     mem_waddr = fw;
                     mem_wdata = {wacc_ff, req_msg_byte};
                  end
                  if (fill_ff == 6'd63) begin
                     state_in = ST_LOAD;
                     post_in  = req_end_of_message ? POST_PAD : POST_IDLE;
                  end else if (req_end_of_message) begin
                     state_in = ST_PAD;
                  end
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            mem_we    = 1'b1;
            mem_waddr = fw;
            mem_wdata = pad_word;
            if (fw == widx_type'(15)) begin
               widx_in  = '0;
               two_in   = 1'b0;
               post_in  = POST_ZERO;
               state_in = ST_LOAD;
            end else begin
               widx_in  = fw + widx_type'(1);
               two_in   = (fw == widx_type'(14));
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (!two_ff && widx_ff == widx_type'(14)) begin
               state_in = ST_LEN;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = widx_ff;
               mem_wdata = '0;
               if (widx_ff == widx_type'(15)) begin
                  widx_in  = '0;
                  two_in   = 1'b0;
                  post_in  = POST_ZERO;
                  state_in = ST_LOAD;
               end else begin
                  widx_in = widx_ff + widx_type'(1);
               end
            end
         end
         ST_LEN: begin
            mem_we    = 1'b1;
            mem_waddr = widx_ff;
            mem_wdata = widx_ff[0] ? bitlen_ff[31:0] : bitlen_ff[63:32];
            if (widx_ff == widx_type'(15)) begin
               post_in  = POST_DELIVER;
               state_in = ST_LOAD;
            end else begin
               widx_in = widx_type'(15);
            end
         end
         ST_LOAD: begin
            mem_raddr = '0;
            a_in      = h_ff[0];
            b_in      = h_ff[1];
            c_in      = h_ff[2];
            d_in      = h_ff[3];
            e_in      = h_ff[4];
            round_in  = '0;
            state_in  = ST_ROUND;
         end
         ST_ROUND: begin
            mem_raddr = round_ff[3:0] + widx_type'(1);
            a_in = t_cur;
            b_in = a_ff;
            c_in = rotl30(b_ff);
            d_in = c_ff;
            e_in = d_ff;
            for (int i = 0; i < BufWords - 1; i++) begin
               sched_in[i] = sched_ff[i+1];
            end
            sched_in[BufWords-1] = w_cur;
            round_in = round_ff + round_type'(1);
            if (round_ff == LastRound) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            h_in[0] = h_ff[0] + a_ff;
            h_in[1] = h_ff[1] + b_ff;
            h_in[2] = h_ff[2] + c_ff;
            h_in[3] = h_ff[3] + d_ff;
            h_in[4] = h_ff[4] + e_ff;
            case (post_ff)
               POST_IDLE:    state_in = ST_IDLE;
               POST_PAD:     state_in = ST_PAD;
               POST_ZERO:    state_in = ST_ZERO;
               POST_DELIVER: state_in = ST_DELIVER;
               default:      state_in = ST_IDLE;
            endcase
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               dig_in       = h_ff;
               rsp_valid_in = 1'b1;
               h_in[0]      = H0;
               h_in[1]      = H1;
               h_in[2]      = H2;
               h_in[3]      = H3;
               h_in[4]      = H4;
               fill_in      = '0;
               bitlen_in    = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         post_ff      <= POST_IDLE;
         fill_ff      <= '0;
         bitlen_ff    <= '0;
         widx_ff      <= '0;
         two_ff       <= 1'b0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         h_ff[0]      <= H0;
         h_ff[1]      <= H1;
         h_ff[2]      <= H2;
         h_ff[3]      <= H3;
         h_ff[4]      <= H4;
      end else begin
         state_ff     <= state_in;
         post_ff      <= post_in;
         fill_ff      <= fill_in;
         bitlen_ff    <= bitlen_in;
         widx_ff      <= widx_in;
         two_ff       <= two_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         h_ff         <= h_in;
      end
      wacc_ff  <= wacc_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      e_ff     <= e_in;
      sched_ff <= sched_in;
      dig_ff   <= dig_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digest_word0 = dig_ff[0];
   assign rsp_digest_word1 = dig_ff[1];
   assign rsp_digest_word2 = dig_ff[2];
   assign rsp_digest_word3 = dig_ff[3];
   assign rsp_digest_word4 = dig_ff[4];

endmodule

### tb/sha1_digest_checker.sv
// ----------------------------------------------------------------------------
// sha1_digest_checker
// Watches the byte and digest channels of the SHA-1 engine. Every accepted
// byte goes through a local SHA-1 (buffer, bit count, padding, compression);
// each closed message queues its digest, and every digest transfer is checked
// word by word against the oldest queued one.
// ----------------------------------------------------------------------------
module sha1_digest_checker
   import sha1md_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  word_type    rsp_digest_word0,
   input  word_type    rsp_digest_word1,
   input  word_type    rsp_digest_word2,
   input  word_type    rsp_digest_word3,
   input  word_type    rsp_digest_word4,
   output int unsigned mismatch_count,
   output int unsigned digests_pending
);

   typedef logic [NumChain-1:0][WordWidth-1:0] digest_type;

   logic [7:0]  msg_block [64];
   int unsigned msg_fill;
   logic [63:0] msg_bits;
   word_type    chain [NumChain];
   digest_type  expected_digests [$];

   function automatic void restart_message();
      msg_fill = 0;
      msg_bits = '0;
      chain[0] = H0;
      chain[1] = H1;
      chain[2] = H2;
      chain[3] = H3;
      chain[4] = H4;
   endfunction

   function automatic void compress_block();
      word_type sched [Rounds];
      word_type a, b, c, d, e, f, k, t;
      int r;
      for (r = 0; r < 16; r++)
         sched[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
      for (r = 16; r < Rounds; r++) begin
         t = sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16];
         sched[r] = {t[30:0], t[31]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (r = 0; r < Rounds; r++) begin
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K2;
         end else begin
            f = b ^ c ^ d;
            k = K3;
         end
         t = {a[26:0], a[31:27]} + f + e + k + sched[r];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      chain[0] = chain[0] + a;
      chain[1] = chain[1] + b;
      chain[2] = chain[2] + c;
      chain[3] = chain[3] + d;
      chain[4] = chain[4] + e;
   endfunction

   function automatic void absorb_byte(input logic [7:0] value);
      msg_block[msg_fill] = value;
      msg_fill = msg_fill + 1;
      msg_bits = msg_bits + 64'd8;
      if (msg_fill == 64) begin
         compress_block();
         msg_fill = 0;
      end
   endfunction

   // pad mark, zeros, big-endian bit count; one extra block when the mark lands at byte 56 or later
   function automatic digest_type close_message();
      digest_type  dg;
      int unsigned i;
      int          n;
      i = msg_fill;
      msg_block[i] = PadMark;
      i = i + 1;
      if (i > 56) begin
         while (i < 64) begin
            msg_block[i] = 8'h00;
            i = i + 1;
         end
         compress_block();
         i = 0;
      end
      while (i < 56) begin
         msg_block[i] = 8'h00;
         i = i + 1;
      end
      for (n = 0; n < 8; n++)
         msg_block[56+n] = msg_bits[63-8*n -: 8];
      compress_block();
      for (n = 0; n < NumChain; n++)
         dg[n] = chain[n];
      return dg;
   endfunction

   function automatic void note_failure(input string what);
      mismatch_count = mismatch_count + 1;
      if (mismatch_count <= 10)
         $display("mismatch: %s", what);
   endfunction

   always @(posedge clock) begin
      digest_type got;
      digest_type want;
      int         n;
      if (reset) begin
         restart_message();
         expected_digests.delete();
         mismatch_count = 0;
         digests_pending = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_byte_present)
               absorb_byte(req_msg_byte);
            if (req_end_of_message) begin
               expected_digests.push_back(close_message());
               restart_message();
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_digest_word4, rsp_digest_word3, rsp_digest_word2,
                   rsp_digest_word1, rsp_digest_word0};
            if (expected_digests.size() == 0) begin
               note_failure($sformatf("digest %h with none expected", got));
            end else begin
               want = expected_digests.pop_front();
               for (n = 0; n < NumChain; n++)
                  if (got[n] !== want[n])
                     note_failure($sformatf("digest word %0d expected %h actual %h",
                                            n, want[n], got[n]));
            end
         end
         digests_pending = expected_digests.size();
      end
   end

endmodule

### tb/tb_sha1_message_digest_top.sv
// ----------------------------------------------------------------------------
// tb_sha1_message_digest_top
// Drives byte streams into the SHA-1 engine: a few directed messages (empty,
// end mark with and without a byte, ignored items, extreme bytes), then random
// messages clustered around the padding boundaries, with random gaps on the
// byte side and random stalls on the digest side. The checker does the
// comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_sha1_message_digest_top
   import sha1md_pkg::*;
();

   localparam int unsigned ItemTarget  = 1950;
   localparam int unsigned CalmItems   = 200;
   localparam int unsigned MinMessages = 40;
   localparam int unsigned DrainCycles = 400;
   localparam int unsigned CycleLimit  = 1000000;

   logic       clock;
   logic       reset              = 1'b1;
   logic       req_valid          = 1'b0;
   logic       req_stall;
   logic [7:0] req_msg_byte       = 8'h00;
   logic       req_byte_present   = 1'b0;
   logic       req_end_of_message = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall          = 1'b0;
   word_type   rsp_digest_word0, rsp_digest_word1, rsp_digest_word2;
   word_type   rsp_digest_word3, rsp_digest_word4;

   int unsigned mismatch_count;
   int unsigned digests_pending;
   int unsigned items_sent     = 0;
   int unsigned messages_sent  = 0;
   int unsigned cycle_count    = 0;
   int unsigned rsp_stall_left = 0;
   int unsigned rsp_window     = 0;
   bit          rsp_stalls_on  = 1'b1;
   bit          req_gaps_on    = 1'b1;
   bit          calm           = 1'b0;
   int unsigned pad_edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

   sha1_message_digest_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_msg_byte       (req_msg_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word0   (rsp_digest_word0),
      .rsp_digest_word1   (rsp_digest_word1),
      .rsp_digest_word2   (rsp_digest_word2),
      .rsp_digest_word3   (rsp_digest_word3),
      .rsp_digest_word4   (rsp_digest_word4)
   );

   sha1_digest_checker digest_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_msg_byte       (req_msg_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word0   (rsp_digest_word0),
      .rsp_digest_word1   (rsp_digest_word1),
      .rsp_digest_word2   (rsp_digest_word2),
      .rsp_digest_word3   (rsp_digest_word3),
      .rsp_digest_word4   (rsp_digest_word4),
      .mismatch_count     (mismatch_count),
      .digests_pending    (digests_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // digest side: stall bursts, with quiet windows
   always @(posedge clock) begin
      if (rsp_window == 0) begin
         rsp_window = 300;
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
      end
      rsp_window = rsp_window - 1;
      if (rsp_stall_left == 0 && rsp_stalls_on && !calm && !reset
          && $urandom_range(0, 5) == 0)
         rsp_stall_left = $urandom_range(1, 18);
      if (rsp_stall_left != 0) begin
         rsp_stall <= 1'b1;
         rsp_stall_left = rsp_stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_item(input logic [7:0] value, input logic present, input logic last);
      if (!calm && req_gaps_on && $urandom_range(0, 6) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_msg_byte       <= value;
      req_byte_present   <= present;
      req_end_of_message <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent = items_sent + 1;
      if (items_sent + CalmItems >= ItemTarget)
         calm = 1'b1;
   endtask

   task automatic send_message(input int unsigned len);
      bit          end_with_byte;
      int unsigned i;
      end_with_byte = $urandom_range(0, 1);
      req_gaps_on = ($urandom_range(0, 3) != 0);
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 11) == 0)
            send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, end_with_byte && i == len - 1);
      end
      if (len == 0 || !end_with_byte)
         send_item(8'($urandom), 1'b0, 1'b1);
      messages_sent = messages_sent + 1;
   endtask

   function automatic int unsigned pick_length();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom_range(0, 20);
         4, 5, 6:    return pad_edges[$urandom_range(0, 9)];
         7, 8:       return $urandom_range(0, 130);
         default:    return ($urandom_range(0, 19) == 0) ? $urandom_range(200, 400)
                                                         : $urandom_range(21, 70);
      endcase
   endfunction

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_item(8'h5A, 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hA5, 1'b0, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h62, 1'b1, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h7F, 1'b1, 1'b0);
      send_item(8'h01, 1'b0, 1'b1);

      while (items_sent < ItemTarget || messages_sent < MinMessages)
         send_message(pick_length());

      req_valid <= 1'b0;
      @(posedge clock);
      while (digests_pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && digests_pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      wait (cycle_count >= CycleLimit);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
